FILE: hw/rtl/ir_pulse_width_frame_encoder_core_assert.svh
// Assertion macros used by the checker file of the frame encoder.
`ifndef IR_PULSE_WIDTH_FRAME_ENCODER_CORE_ASSERT_SVH
`define IR_PULSE_WIDTH_FRAME_ENCODER_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define IRPW_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define IRPW_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/irpw_pkg.sv
// Shared types and constants of the pulse-width frame encoder.
`timescale 1ns / 1ps
package irpw_pkg;

    localparam int CODE_W      = 4;
    localparam int REG_W       = 16;
    localparam int DUR_W       = 17;
    localparam int IDX_W       = 3;
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [IDX_W-1:0] {
        REG_LEADER_MARK  = 3'd0,
        REG_LEADER_SPACE = 3'd1,
        REG_ONE_MARK     = 3'd2,
        REG_ZERO_MARK    = 3'd3,
        REG_BIT_SPACE    = 3'd4,
        REG_STOP_MARK    = 3'd5,
        REG_END_GAP      = 3'd6
    } reg_idx_t;

    localparam logic [REG_W-1:0] RST_LEADER_MARK  = 16'd16800;
    localparam logic [REG_W-1:0] RST_LEADER_SPACE = 16'd8400;
    localparam logic [REG_W-1:0] RST_ONE_MARK     = 16'd1844;
    localparam logic [REG_W-1:0] RST_ZERO_MARK    = 16'd524;
    localparam logic [REG_W-1:0] RST_BIT_SPACE    = 16'd500;
    localparam logic [REG_W-1:0] RST_STOP_MARK    = 16'd526;
    localparam logic [REG_W-1:0] RST_END_GAP      = 16'd20000;

    typedef struct packed {
        logic [REG_W-1:0] leader_mark;
        logic [REG_W-1:0] leader_space;
        logic [REG_W-1:0] one_mark;
        logic [REG_W-1:0] zero_mark;
        logic [REG_W-1:0] bit_space;
        logic [REG_W-1:0] stop_mark;
        logic [REG_W-1:0] end_gap;
    } cfg_t;

    // A button code moving from the front end through the queue.
    typedef struct packed {
        logic              valid;
        logic [CODE_W-1:0] code;
    } code_word_t;

endpackage

FILE: hw/rtl/irpw_if.sv
// Handshake interfaces for the button sample and segment channels.
`timescale 1ns / 1ps
interface irpw_btn_if;
    logic valid;
    logic ready;
    logic up_n;
    logic down_n;
    logic left_n;
    logic right_n;

    modport source (output valid, output up_n, output down_n, output left_n,
                    output right_n, input ready);
    modport sink (input valid, input up_n, input down_n, input left_n,
                  input right_n, output ready);
endinterface

interface irpw_seg_if import irpw_pkg::*;;
    logic             valid;
    logic             ready;
    logic             carrier_on;
    logic [DUR_W-1:0] duration;
    logic             last;

    modport source (output valid, output carrier_on, output duration, output last,
                    input ready);
    modport sink (input valid, input carrier_on, input duration, input last,
                  output ready);
endinterface

FILE: hw/rtl/irpw_front.sv
// Front end: takes button samples and forwards pressed-button codes.
`timescale 1ns / 1ps
module irpw_front
    import irpw_pkg::*;
(
    irpw_btn_if.sink   btn,
    input  logic       q_ready,
    output code_word_t push
);

    logic [CODE_W-1:0] code;

    // Buttons are active low; up is bit 0 through right at bit 3.
    assign code = ~{btn.right_n, btn.left_n, btn.down_n, btn.up_n};

    assign btn.ready  = q_ready;
    // A sample with no button pressed is consumed and dropped here.
    assign push.valid = btn.valid && q_ready && (code != '0);
    assign push.code  = code;

endmodule

FILE: hw/rtl/irpw_queue.sv
// Short code queue between the front end and the segment sequencer.
`timescale 1ns / 1ps
module irpw_queue
    import irpw_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  code_word_t push,
    output logic       ready,
    output code_word_t head,
    input  logic       pop
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [CODE_W-1:0] mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              do_pop;

    assign ready      = (count_reg != CNT_W'(QUEUE_DEPTH));
    assign head.valid = (count_reg != '0);
    assign head.code  = mem_reg[rd_ptr_reg];
    assign do_pop     = pop && head.valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push.valid)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push.valid && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!push.valid && do_pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.valid)
        begin
            mem_reg[wr_ptr_reg] <= push.code;
        end
    end

endmodule

FILE: hw/rtl/irpw_seq.sv
// Back end: steps through the segments of a frame into an output register.
`timescale 1ns / 1ps
module irpw_seq
    import irpw_pkg::*;
#(
    parameter int FRAME_BITS = 8
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  cfg_t       cfg,
    input  code_word_t head,
    output logic       pop,
    irpw_seg_if.source seg
);

    localparam int NUM_SEGS = 2 * FRAME_BITS + 4;
    localparam int SEG_W    = $clog2(NUM_SEGS);
    localparam logic [SEG_W-1:0] LAST_SEG = SEG_W'(NUM_SEGS - 1);
    localparam logic [SEG_W-1:0] STOP_SEG = SEG_W'(NUM_SEGS - 2);

    logic              busy_reg, busy_next;
    logic [SEG_W-1:0]  seg_reg, seg_next;
    logic [CODE_W-1:0] code_reg;
    logic              out_valid_reg, out_valid_next;
    logic              carrier_reg;
    logic [DUR_W-1:0]  dur_reg;
    logic              last_reg;

    logic [SEG_W-1:0]  cur_seg;
    logic [CODE_W-1:0] cur_code;
    logic [SEG_W-1:0]  bit_off;
    logic [SEG_W-2:0]  bit_idx;
    logic              bit_val;
    logic [REG_W-1:0]  sel_len;
    logic              sel_carrier;
    logic              sel_last;
    logic              slot_free;
    logic              emit;

    assign slot_free = !out_valid_reg || seg.ready;
    assign emit      = (busy_reg || head.valid) && slot_free;
    assign pop       = emit && !busy_reg;
    assign cur_seg   = busy_reg ? seg_reg : '0;
    assign cur_code  = busy_reg ? code_reg : head.code;

    // Data segments alternate mark and space, two per bit, LSB first.
    assign bit_off = cur_seg - SEG_W'(2);
    assign bit_idx = bit_off[SEG_W-1:1];
    assign bit_val = (int'(bit_idx) < CODE_W) ? cur_code[bit_idx[1:0]] : 1'b0;

    always_comb
    begin
        sel_len     = cfg.bit_space;
        sel_carrier = 1'b0;
        sel_last    = 1'b0;
        if (cur_seg == '0)
        begin
            sel_len     = cfg.leader_mark;
            sel_carrier = 1'b1;
        end
        else if (cur_seg == SEG_W'(1))
        begin
            sel_len = cfg.leader_space;
        end
        else if (cur_seg == STOP_SEG)
        begin
            sel_len     = cfg.stop_mark;
            sel_carrier = 1'b1;
        end
        else if (cur_seg == LAST_SEG)
        begin
            sel_len  = cfg.end_gap;
            sel_last = 1'b1;
        end
        else if (!bit_off[0])
        begin
            sel_len     = bit_val ? cfg.one_mark : cfg.zero_mark;
            sel_carrier = 1'b1;
        end
    end

    always_comb
    begin
        busy_next      = busy_reg;
        seg_next       = seg_reg;
        out_valid_next = out_valid_reg;
        if (seg.ready)
        begin
            out_valid_next = 1'b0;
        end
        if (emit)
        begin
            out_valid_next = 1'b1;
            if (cur_seg == LAST_SEG)
            begin
                busy_next = 1'b0;
                seg_next  = '0;
            end
            else
            begin
                busy_next = 1'b1;
                seg_next  = cur_seg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            seg_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            seg_reg       <= seg_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            code_reg <= head.code;
        end
        if (emit)
        begin
            carrier_reg <= sel_carrier;
            dur_reg     <= {1'b0, sel_len} + DUR_W'(1);
            last_reg    <= sel_last;
        end
    end

    assign seg.valid      = out_valid_reg;
    assign seg.carrier_on = carrier_reg;
    assign seg.duration   = dur_reg;
    assign seg.last       = last_reg;

endmodule

FILE: hw/rtl/ir_pulse_width_frame_encoder_core.sv
// Top level of the pulse-width infrared frame encoder.
`timescale 1ns / 1ps
// Each word on btn is one sample of four active-low direction buttons. A
// sample with no button pressed is consumed and produces nothing. Any other
// sample becomes a 4-bit code (up in bit 0, down, left, right in bit 3) and
// is sent as one frame of carrier segments on seg: a leader mark, a leader
// space, FRAME_BITS data bits LSB first (each a mark, long for a one and
// short for a zero, then a bit space), a stop mark and a final gap, which
// is the only word flagged with last. A segment's duration is its register
// value plus one timer tick. The front end parks the code in a two-entry
// queue; the sequencer behind it writes one segment word per cycle into an
// output register while the sink takes each word, and the first word of the
// next queued frame follows the final gap directly. The one-word-per-cycle
// output register is what sets that rate. While a frame is playing, up to
// two more pressed samples are taken before btn.ready drops. The seven
// length registers are written through wr_en, wr_index and wr_data; an
// index past the last register is ignored. They must only be changed while
// no frame is queued or playing, since the sequencer reads them live.
module ir_pulse_width_frame_encoder_core
    import irpw_pkg::*;
#(
    parameter int FRAME_BITS = 8
)
(
    input  logic             clk,
    input  logic             rst_n,
    irpw_btn_if.sink         btn,
    irpw_seg_if.source       seg,
    input  logic             wr_en,
    input  logic [IDX_W-1:0] wr_index,
    input  logic [REG_W-1:0] wr_data
);

    cfg_t       cfg_reg;
    code_word_t push;
    code_word_t head;
    logic       q_ready;
    logic       pop;

    // Configuration registers; writes to an unused index fall through.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.leader_mark  <= RST_LEADER_MARK;
            cfg_reg.leader_space <= RST_LEADER_SPACE;
            cfg_reg.one_mark     <= RST_ONE_MARK;
            cfg_reg.zero_mark    <= RST_ZERO_MARK;
            cfg_reg.bit_space    <= RST_BIT_SPACE;
            cfg_reg.stop_mark    <= RST_STOP_MARK;
            cfg_reg.end_gap      <= RST_END_GAP;
        end
        else if (wr_en)
        begin
            case (wr_index)
                REG_LEADER_MARK:  cfg_reg.leader_mark  <= wr_data;
                REG_LEADER_SPACE: cfg_reg.leader_space <= wr_data;
                REG_ONE_MARK:     cfg_reg.one_mark     <= wr_data;
                REG_ZERO_MARK:    cfg_reg.zero_mark    <= wr_data;
                REG_BIT_SPACE:    cfg_reg.bit_space    <= wr_data;
                REG_STOP_MARK:    cfg_reg.stop_mark    <= wr_data;
                REG_END_GAP:      cfg_reg.end_gap      <= wr_data;
                default:          cfg_reg              <= cfg_reg;
            endcase
        end
    end

    // The front end classifies samples and drops those with no button pressed.
    irpw_front u_front (
        .btn     (btn),
        .q_ready (q_ready),
        .push    (push)
    );

    // The queue lets the front end keep taking samples during a frame.
    irpw_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .ready (q_ready),
        .head  (head),
        .pop   (pop)
    );

    // The sequencer walks the frame one segment per cycle while the sink is ready.
    irpw_seq #(
        .FRAME_BITS (FRAME_BITS)
    ) u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_reg),
        .head  (head),
        .pop   (pop),
        .seg   (seg)
    );

endmodule

FILE: hw/rtl/irpw_checker.sv
// Port-level checker for the frame encoder, bound to the top level.
`timescale 1ns / 1ps
`include "ir_pulse_width_frame_encoder_core_assert.svh"
module irpw_checker
    import irpw_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             seg_valid,
    input logic             seg_ready,
    input logic             carrier_on,
    input logic [DUR_W-1:0] duration,
    input logic             last
);

    logic [DUR_W+1:0] payload;
    logic             seg_acc;
    logic             expect_leader_reg;
    logic             prev_carrier_reg;

    assign payload = {carrier_on, duration, last};
    assign seg_acc = seg_valid && seg_ready;

    // A frame opens with a mark right after reset or after a final gap.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expect_leader_reg <= 1'b1;
            prev_carrier_reg  <= 1'b0;
        end
        else if (seg_acc)
        begin
            expect_leader_reg <= last;
            prev_carrier_reg  <= carrier_on;
        end
    end

    `IRPW_ASSERT_NXT(a_stall_hold, clk, rst_n, seg_valid && !seg_ready,
        seg_valid && $stable(payload), "segment word changed while stalled")
    `IRPW_ASSERT_IMP(a_last_silent, clk, rst_n, seg_valid && last,
        !carrier_on, "final gap carries the carrier")
    `IRPW_ASSERT_IMP(a_leader_first, clk, rst_n, seg_acc && expect_leader_reg,
        carrier_on && !last, "frame does not open with a mark")
    `IRPW_ASSERT_IMP(a_alternate, clk, rst_n, seg_acc && !expect_leader_reg,
        carrier_on != prev_carrier_reg, "marks and spaces do not alternate")

endmodule

bind ir_pulse_width_frame_encoder_core irpw_checker u_irpw_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .seg_valid  (seg.valid),
    .seg_ready  (seg.ready),
    .carrier_on (seg.carrier_on),
    .duration   (seg.duration),
    .last       (seg.last)
);

FILE: verif/ir_pulse_width_frame_encoder_core_tb.sv
// Self-checking testbench for the pulse-width infrared frame encoder core.
`timescale 1ns / 1ps
// The testbench feeds button sample words into the encoder and checks every
// segment word that comes back. It keeps its own copy of the seven length
// registers. For each accepted sample it predicts the frame: leader mark,
// leader space, eight data bits LSB first, stop mark and final gap. Segment
// words are compared in order with the oldest prediction.
//
// The run has two parts. A short directed part comes first. It sends every
// button combination at the reset lengths, including the sample with no
// button pressed. It then sends a few frames with all lengths at zero and
// with all lengths at full scale. Several random phases follow. Each one
// reprograms the lengths (the second and fourth in the same style) and uses
// a different mix of sender and receiver idling. One phase also holds the
// sender until its frames have fully drained. The last phase runs with no
// idling at all. Lengths are only reprogrammed while the encoder is idle.
module ir_pulse_width_frame_encoder_core_tb;
    import irpw_pkg::*;

    localparam int FRAME_BITS    = 8;
    localparam int NUM_LENGTHS   = 7;
    // Drain time after the last segment word, counted in clock edges.
    localparam int DRAIN_CYCLES  = 8;
    // Longest run of cycles with no word moving on either channel.
    localparam int QUIET_LIMIT   = 1000;
    localparam int RANDOM_PHASES = 4;
    localparam int PHASE_ITEMS   = 58;

    // Register index past the last length register. Writes to it must be ignored.
    localparam logic [IDX_W-1:0] REG_NONE = 3'd7;

    // Button sample as a 4-bit value; bit 0 is up, bit 3 is right.
    typedef struct packed {
        logic right_n;
        logic left_n;
        logic down_n;
        logic up_n;
    } sample_t;

    typedef struct packed {
        logic             carrier_on;
        logic [DUR_W-1:0] duration;
        logic             last;
    } segment_t;

    // How a phase picks its register lengths.
    typedef enum int {
        LEN_ZERO,
        LEN_FULL,
        LEN_SMALL,
        LEN_WIDE,
        LEN_EDGE_MIX
    } len_style_t;

    localparam sample_t NONE_PRESSED = 4'hF;
    localparam sample_t ALL_PRESSED  = 4'h0;

    logic             clk = 1'b0;
    logic             rst_n;
    logic             wr_en;
    logic [IDX_W-1:0] wr_index;
    logic [REG_W-1:0] wr_data;

    irpw_btn_if btn_if();
    irpw_seg_if seg_if();

    ir_pulse_width_frame_encoder_core #(
        .FRAME_BITS(FRAME_BITS)
    ) i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .btn     (btn_if),
        .seg     (seg_if),
        .wr_en   (wr_en),
        .wr_index(wr_index),
        .wr_data (wr_data)
    );

    // Testbench copy of the length registers.
    logic [REG_W-1:0] seg_len [NUM_LENGTHS];

    sample_t  sample_q[$];       // samples waiting to be sent
    segment_t frame_q[$];        // predicted segment words, oldest first
    int       samples_owed = 0;  // queued or in flight, not yet accepted
    int       err_count    = 0;
    int       seg_count    = 0;
    int       quiet_cycles = 0;
    int       src_gap      = 0;
    int       snk_gap      = 0;
    bit       src_idle_en  = 1'b1;
    bit       snk_idle_en  = 1'b1;
    bit       src_hold     = 1'b0;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic void note_mismatch(string msg);
        err_count++;
        if (err_count <= 10)
        begin
            $display("[%0t] mismatch: %s", $realtime, msg);
        end
    endfunction

    function automatic void add_segment(logic carrier, logic [REG_W-1:0] len, logic fin);
        segment_t word;
        word.carrier_on = carrier;
        word.duration   = {1'b0, len} + DUR_W'(1);
        word.last       = fin;
        frame_q.push_back(word);
    endfunction

    // Predict the segment words for one button sample. A sample with no button
    // pressed gives no words. Data bits above the 4-bit code go out as zeros.
    function automatic void predict_frame(sample_t s);
        logic [CODE_W-1:0]     pressed;
        logic [FRAME_BITS-1:0] code;
        pressed = ~s;
        if (pressed == '0)
        begin
            return;
        end
        code = FRAME_BITS'(pressed);
        add_segment(1'b1, seg_len[REG_LEADER_MARK], 1'b0);
        add_segment(1'b0, seg_len[REG_LEADER_SPACE], 1'b0);
        for (int i = 0; i < FRAME_BITS; i++)
        begin
            add_segment(1'b1, code[i] ? seg_len[REG_ONE_MARK] : seg_len[REG_ZERO_MARK], 1'b0);
            add_segment(1'b0, seg_len[REG_BIT_SPACE], 1'b0);
        end
        add_segment(1'b1, seg_len[REG_STOP_MARK], 1'b0);
        add_segment(1'b0, seg_len[REG_END_GAP], 1'b1);
    endfunction

    task automatic queue_sample(sample_t s);
        sample_q.push_back(s);
        samples_owed++;
    endtask

    // Wait until every sample has been taken and every predicted word has come
    // back. Then let the front end drain.
    task automatic settle();
        do
        begin
            @(posedge clk);
        end
        while (samples_owed != 0 || frame_q.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_len(logic [IDX_W-1:0] idx, logic [REG_W-1:0] val);
        @(posedge clk);
        wr_en    <= 1'b1;
        wr_index <= idx;
        wr_data  <= val;
        if (idx <= REG_END_GAP)
        begin
            seg_len[idx] = val;
        end
    endtask

    // Write all seven lengths in the given style. Then write the unused index,
    // which the encoder must drop.
    task automatic program_lengths(len_style_t style);
        logic [REG_W-1:0] val;
        for (int r = 0; r < NUM_LENGTHS; r++)
        begin
            case (style)
                LEN_ZERO:  val = '0;
                LEN_FULL:  val = '1;
                LEN_SMALL: val = REG_W'($urandom_range(0, 15));
                LEN_WIDE:  val = REG_W'($urandom());
                default:
                begin
                    case ($urandom_range(0, 2))
                        0:       val = '0;
                        1:       val = '1;
                        default: val = REG_W'($urandom());
                    endcase
                end
            endcase
            write_len(IDX_W'(r), val);
        end
        write_len(REG_NONE, REG_W'($urandom()));
        @(posedge clk);
        wr_en <= 1'b0;
    endtask

    // Sample driver. A word stays on the bus until it is taken. Idle gaps are
    // only placed before a new word is raised.
    always @(posedge clk or negedge rst_n)
    begin
        sample_t nxt;
        sample_t taken;
        if (!rst_n)
        begin
            btn_if.valid   <= 1'b0;
            btn_if.up_n    <= 1'b1;
            btn_if.down_n  <= 1'b1;
            btn_if.left_n  <= 1'b1;
            btn_if.right_n <= 1'b1;
            src_gap        <= 0;
        end
        else
        begin
            if (btn_if.valid && btn_if.ready)
            begin
                taken.up_n    = btn_if.up_n;
                taken.down_n  = btn_if.down_n;
                taken.left_n  = btn_if.left_n;
                taken.right_n = btn_if.right_n;
                predict_frame(taken);
                samples_owed--;
            end
            if (!btn_if.valid || btn_if.ready)
            begin
                if (src_gap != 0)
                begin
                    src_gap      <= src_gap - 1;
                    btn_if.valid <= 1'b0;
                end
                else if (sample_q.size() != 0 && !src_hold)
                begin
                    if (src_idle_en && $urandom_range(0, 3) == 0)
                    begin
                        // Idle now and for a random extra gap before raising the next word.
                        src_gap      <= $urandom_range(0, 2);
                        btn_if.valid <= 1'b0;
                    end
                    else
                    begin
                        nxt = sample_q.pop_front();
                        btn_if.valid   <= 1'b1;
                        btn_if.up_n    <= nxt.up_n;
                        btn_if.down_n  <= nxt.down_n;
                        btn_if.left_n  <= nxt.left_n;
                        btn_if.right_n <= nxt.right_n;
                    end
                end
                else
                begin
                    btn_if.valid <= 1'b0;
                end
            end
        end
    end

    // The receiver's ready signal, with random stalls when enabled.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seg_if.ready <= 1'b0;
            snk_gap      <= 0;
        end
        else if (snk_gap != 0)
        begin
            seg_if.ready <= 1'b0;
            snk_gap      <= snk_gap - 1;
        end
        else if (snk_idle_en && $urandom_range(0, 3) == 0)
        begin
            seg_if.ready <= 1'b0;
            snk_gap      <= $urandom_range(0, 2);
        end
        else
        begin
            seg_if.ready <= 1'b1;
        end
    end

    // Segment monitor. Each word taken is checked against the oldest prediction.
    always @(posedge clk)
    begin
        segment_t want;
        if (rst_n && seg_if.valid && seg_if.ready)
        begin
            if (frame_q.size() == 0)
            begin
                note_mismatch($sformatf("segment %0d with nothing expected: carrier_on=%0b duration=%0d last=%0b",
                                        seg_count, seg_if.carrier_on, seg_if.duration, seg_if.last));
            end
            else
            begin
                want = frame_q.pop_front();
                if (seg_if.carrier_on !== want.carrier_on || seg_if.duration !== want.duration ||
                    seg_if.last !== want.last)
                begin
                    note_mismatch($sformatf({"segment %0d: expected carrier_on=%0b duration=%0d last=%0b,",
                                             " got carrier_on=%0b duration=%0d last=%0b"},
                                            seg_count, want.carrier_on, want.duration, want.last,
                                            seg_if.carrier_on, seg_if.duration, seg_if.last));
                end
            end
            seg_count++;
        end
    end

    // Count cycles in which no word moves on either channel.
    always @(posedge clk)
    begin
        if ((btn_if.valid && btn_if.ready) || (seg_if.valid && seg_if.ready))
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("status: fail");
        $finish;
    end

    initial
    begin
        sample_t s;
        rst_n          = 1'b0;
        wr_en          = 1'b0;
        wr_index       = '0;
        wr_data        = '0;
        btn_if.valid   = 1'b0;
        btn_if.up_n    = 1'b1;
        btn_if.down_n  = 1'b1;
        btn_if.left_n  = 1'b1;
        btn_if.right_n = 1'b1;
        seg_if.ready   = 1'b0;

        seg_len[REG_LEADER_MARK]  = RST_LEADER_MARK;
        seg_len[REG_LEADER_SPACE] = RST_LEADER_SPACE;
        seg_len[REG_ONE_MARK]     = RST_ONE_MARK;
        seg_len[REG_ZERO_MARK]    = RST_ZERO_MARK;
        seg_len[REG_BIT_SPACE]    = RST_BIT_SPACE;
        seg_len[REG_STOP_MARK]    = RST_STOP_MARK;
        seg_len[REG_END_GAP]      = RST_END_GAP;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Send every button combination at the reset lengths. The combination
        // with no button pressed must give no words at all.
        for (int v = 0; v < 16; v++)
        begin
            queue_sample(sample_t'(v));
        end
        settle();

        // Set every length to its lowest value and then to its highest value.
        program_lengths(LEN_ZERO);
        queue_sample(ALL_PRESSED);
        queue_sample(4'hE);
        queue_sample(NONE_PRESSED);
        queue_sample(4'h7);
        settle();

        program_lengths(LEN_FULL);
        queue_sample(ALL_PRESSED);
        queue_sample(4'hA);
        queue_sample(NONE_PRESSED);
        queue_sample(4'h5);
        settle();

        // Random phases. Each one has its own lengths and its own idling mix.
        // The last phase runs with no idling on either side.
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            case (p)
                0:       program_lengths(LEN_WIDE);
                1:       program_lengths(LEN_SMALL);
                2:       program_lengths(LEN_EDGE_MIX);
                default: program_lengths(LEN_SMALL);
            endcase
            src_idle_en = (p == 0 || p == 1);
            snk_idle_en = (p == 0 || p == 2);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if ($urandom_range(0, 9) == 0)
                begin
                    s = NONE_PRESSED;
                end
                else
                begin
                    s = sample_t'($urandom_range(0, 15));
                end
                queue_sample(s);
            end
            if (p == 2)
            begin
                // Partway through this phase, stop sending. Wait until every
                // frame already taken has fully played out, then resume.
                wait (samples_owed <= PHASE_ITEMS / 2);
                @(posedge clk);
                src_hold = 1'b1;
                do
                begin
                    @(posedge clk);
                end
                while (btn_if.valid || frame_q.size() != 0);
                src_hold = 1'b0;
            end
            settle();
        end

        if (err_count == 0 && frame_q.size() == 0)
        begin
            $display("status: pass");
        end
        else
        begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
